### rtl/etpl_pkg.sv
// Package: shared constants and verdict codes for the Ethernet/IPv4/TCP payload locator.
`default_nettype none

package etpl_pkg;

  // Frame layout
  localparam int unsigned ETH_HDR_BYTES   = 14;
  localparam int unsigned POS_ETYPE_HI    = 12;
  localparam int unsigned POS_ETYPE_LO    = 13;
  localparam int unsigned POS_IHL         = ETH_HDR_BYTES;
  localparam int unsigned POS_PROTO       = ETH_HDR_BYTES + 9;
  // TCP data offset byte sits 12 bytes into the TCP header
  localparam int unsigned TCP_OFFS_BYTE   = 12;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  // Register defaults
  localparam int unsigned MAX_FRAME_BYTES_DEF = 2047;
  localparam logic [10:0] MAX_PAYLOAD_RESET   = 11'd260;

  // Register map
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  // fields_seen bit positions
  localparam int unsigned SEEN_ETYPE = 0;
  localparam int unsigned SEEN_IHL   = 1;
  localparam int unsigned SEEN_PROTO = 2;
  localparam int unsigned SEEN_TCP   = 3;

  // Verdict codes
  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_NOT_IPV4  = 3'd1;
  localparam logic [2:0] VERDICT_NOT_TCP   = 3'd2;
  localparam logic [2:0] VERDICT_BAD_LEN   = 3'd3;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;

endpackage

`default_nettype wire

### rtl/eth_ipv4_tcp_payload_locator.sv
// Top level: Ethernet/IPv4/TCP payload locator, byte-wide frame in, one verdict per frame out.
`default_nettype none

// Frame bytes stream in one item per clock, in wire order, with frame_end on
// the last byte. The block picks off the ethertype (bytes 12-13), the IPv4
// header length (low nibble of byte 14, times 4), the protocol (byte 23) and
// the TCP data offset (high nibble at 14 + IP header length + 12, times 4).
// On the last byte it posts exactly one result: accepted (with payload offset
// and length), not IPv4, not TCP, payload length out of range (zero or less, or above
// max_payload_len), or truncated (frame ended before a needed field). Rate:
// one byte per cycle, sustained; the field capture and the final length
// compare sit between the per-frame capture registers and the result
// register, so a result appears the cycle after its last byte is taken.
// The byte counter saturates at MAX_FRAME_BYTES; later bytes count as none.
// The input stalls only while a posted result is held by out_stall.
// Config: APB register 0 (byte address 0) is max_payload_len, reset 260;
// write it only while no frame is in flight.
module eth_ipv4_tcp_payload_locator
  import etpl_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_end,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       verdict,
  output logic [7:0]       payload_offset,
  output logic [10:0]      payload_bytes
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  // Config register
  logic [10:0] max_payload_len;

  // Per-frame capture state
  logic [CntW-1:0] byte_count;
  logic [15:0]     ether_type_seen;
  logic [5:0]      ip_hdr_bytes;
  logic [7:0]      proto_seen;
  logic [5:0]      tcp_hdr_bytes;
  logic [3:0]      fields_seen;

  logic [CntW-1:0] byte_count_next;
  logic [15:0]     ether_type_seen_next;
  logic [5:0]      ip_hdr_bytes_next;
  logic [7:0]      proto_seen_next;
  logic [5:0]      tcp_hdr_bytes_next;
  logic [3:0]      fields_seen_next;

  logic            in_accept;
  logic            capturing;
  logic [CntW:0]   tcp_pos;
  logic [7:0]      hdrs;
  logic [CntW:0]   caplen_ext;
  logic [CntW:0]   hdrs_ext;
  logic [CntW:0]   pay_len;
  logic [2:0]      verdict_next;

  // ---------------- APB ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {21'd0, max_payload_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_PAYLOAD) begin
      max_payload_len <= pwdata[10:0];
    end
  end

  // ---------------- handshake ----------------
  // Output register holds the result; input only waits when it is stuck.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // ---------------- field capture ----------------
  // TCP offset byte position depends on the IHL captured earlier.
  assign tcp_pos   = (CntW+1)'(ETH_HDR_BYTES + TCP_OFFS_BYTE) + (CntW+1)'(ip_hdr_bytes);
  assign capturing = byte_count < CntMax;

  always_comb begin
    byte_count_next      = byte_count;
    ether_type_seen_next = ether_type_seen;
    ip_hdr_bytes_next    = ip_hdr_bytes;
    proto_seen_next      = proto_seen;
    tcp_hdr_bytes_next   = tcp_hdr_bytes;
    fields_seen_next     = fields_seen;
    if (capturing) begin
      byte_count_next = byte_count + CntW'(1);
      if (byte_count == CntW'(POS_ETYPE_HI)) begin
        ether_type_seen_next[15:8] = frame_byte;
      end else if (byte_count == CntW'(POS_ETYPE_LO)) begin
        ether_type_seen_next[7:0]    = frame_byte;
        fields_seen_next[SEEN_ETYPE] = 1'b1;
      end else if (byte_count == CntW'(POS_IHL)) begin
        ip_hdr_bytes_next          = {frame_byte[3:0], 2'b00};
        fields_seen_next[SEEN_IHL] = 1'b1;
      end else if (byte_count == CntW'(POS_PROTO)) begin
        proto_seen_next              = frame_byte;
        fields_seen_next[SEEN_PROTO] = 1'b1;
      end
      // never coincides with the IHL byte itself (tcp_pos >= 26)
      if (fields_seen[SEEN_IHL] && {1'b0, byte_count} == tcp_pos) begin
        tcp_hdr_bytes_next         = {frame_byte[7:4], 2'b00};
        fields_seen_next[SEEN_TCP] = 1'b1;
      end
    end
  end

  // ---------------- verdict ----------------
  assign hdrs       = 8'(ETH_HDR_BYTES) + {2'b00, ip_hdr_bytes_next}
                    + {2'b00, tcp_hdr_bytes_next};
  assign caplen_ext = {1'b0, byte_count_next};
  assign hdrs_ext   = (CntW+1)'(hdrs);
  assign pay_len    = caplen_ext - hdrs_ext;

  always_comb begin
    if (!fields_seen_next[SEEN_ETYPE]) begin
      verdict_next = VERDICT_TRUNCATED;
    end else if (ether_type_seen_next != ETYPE_IPV4) begin
      verdict_next = VERDICT_NOT_IPV4;
    end else if (!fields_seen_next[SEEN_PROTO]) begin
      verdict_next = VERDICT_TRUNCATED;
    end else if (proto_seen_next != PROTO_TCP) begin
      verdict_next = VERDICT_NOT_TCP;
    end else if (!fields_seen_next[SEEN_TCP]) begin
      verdict_next = VERDICT_TRUNCATED;
    end else if (caplen_ext <= hdrs_ext
                 || pay_len > (CntW+1)'(max_payload_len)) begin
      verdict_next = VERDICT_BAD_LEN;
    end else begin
      verdict_next = VERDICT_ACCEPT;
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      ether_type_seen <= '0;
      ip_hdr_bytes    <= '0;
      proto_seen      <= '0;
      tcp_hdr_bytes   <= '0;
      fields_seen     <= '0;
    end else if (in_accept) begin
      if (frame_end) begin
        // start the next frame clean
        byte_count      <= '0;
        ether_type_seen <= '0;
        ip_hdr_bytes    <= '0;
        proto_seen      <= '0;
        tcp_hdr_bytes   <= '0;
        fields_seen     <= '0;
      end else begin
        byte_count      <= byte_count_next;
        ether_type_seen <= ether_type_seen_next;
        ip_hdr_bytes    <= ip_hdr_bytes_next;
        proto_seen      <= proto_seen_next;
        tcp_hdr_bytes   <= tcp_hdr_bytes_next;
        fields_seen     <= fields_seen_next;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_end) begin
      verdict <= verdict_next;
      if (verdict_next == VERDICT_ACCEPT) begin
        payload_offset <= hdrs;
        payload_bytes  <= pay_len[10:0];
      end else begin
        payload_offset <= 8'd0;
        payload_bytes  <= 11'd0;
      end
    end
  end

`ifndef ASSERT_OFF
  // A frame end always posts a result next cycle.
  a_end_posts: assert property (@(posedge clk) disable iff (rst)
    in_accept && frame_end |=> out_valid)
    else $error("frame end did not post a result");

  // Capture state is cleared after every frame end.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && frame_end |=> byte_count == '0 && fields_seen == '0)
    else $error("frame state not cleared after frame end");

  // Rejected results carry zero offset and length.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_ACCEPT |-> payload_offset == 8'd0
      && payload_bytes == 11'd0)
    else $error("rejected result with nonzero offset or length");

  // Accepted results have a real payload behind a full Ethernet header.
  a_accept_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ACCEPT |-> payload_bytes != 11'd0
      && payload_offset >= 8'(ETH_HDR_BYTES))
    else $error("accepted result with bad offset or length");

  // Input is held off only while a result is stuck.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire

### tb/eth_ipv4_tcp_payload_locator_tb.sv
// Testbench for the Ethernet/IPv4/TCP payload locator: frame stimulus, byte-level predictor, result scoreboard.
module eth_ipv4_tcp_payload_locator_tb;
  import etpl_pkg::*;

  // Byte counter saturation point, matches the block's default parameter
  localparam int FRAME_CAP = MAX_FRAME_BYTES_DEF;
  // Run limit in clock cycles
  localparam int RUN_LIMIT = 1000000;
  // APB byte address of max_payload_len (register index times 4)
  localparam logic [2:0] MAX_PAYLOAD_ADDR = {REG_MAX_PAYLOAD, 2'b00};

  // One input item: a frame byte plus the end-of-frame flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  // One result: verdict with payload position
  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  offset;
    logic [10:0] length;
  } locate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  frame_byte = '0;
  logic        frame_end = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  verdict;
  logic [7:0]  payload_offset;
  logic [10:0] payload_bytes;

  // Bytes waiting to go out, and verdicts waiting to come back
  frame_item_t tx_bytes[$];
  locate_t     pending_verdicts[$];

  // Predictor state: per-frame capture registers plus the config copy
  int          cnt_bytes;
  logic [15:0] etype_cap;
  logic [5:0]  ip_len_cap;
  logic [7:0]  proto_cap;
  logic [5:0]  tcp_len_cap;
  logic [3:0]  seen_cap;
  logic [10:0] cfg_max_len = MAX_PAYLOAD_RESET;

  // Handshake bookkeeping
  logic in_fire = 1'b0;
  int   tx_gap = 0;
  int   rx_hold = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  int   faults = 0;
  int   cycles = 0;

  eth_ipv4_tcp_payload_locator dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .verdict        (verdict),
    .payload_offset (payload_offset),
    .payload_bytes  (payload_bytes)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_capture();
    cnt_bytes   = 0;
    etype_cap   = '0;
    ip_len_cap  = '0;
    proto_cap   = '0;
    tcp_len_cap = '0;
    seen_cap    = '0;
  endfunction

  // Pick off header fields by byte position. The TCP data offset position
  // depends on the IHL seen earlier in the same frame; an IHL below 5 is
  // taken as is, so the offset byte can sit as early as byte 26.
  function automatic void capture_field(int pos, logic [7:0] b);
    if (pos == POS_ETYPE_HI) begin
      etype_cap[15:8] = b;
    end else if (pos == POS_ETYPE_LO) begin
      etype_cap[7:0] = b;
      seen_cap[SEEN_ETYPE] = 1'b1;
    end else if (pos == POS_IHL) begin
      ip_len_cap = {b[3:0], 2'b00};
      seen_cap[SEEN_IHL] = 1'b1;
    end else if (pos == POS_PROTO) begin
      proto_cap = b;
      seen_cap[SEEN_PROTO] = 1'b1;
    end
    if (seen_cap[SEEN_IHL] && pos == ETH_HDR_BYTES + ip_len_cap + TCP_OFFS_BYTE) begin
      tcp_len_cap = {b[7:4], 2'b00};
      seen_cap[SEEN_TCP] = 1'b1;
    end
  endfunction

  // Frame-end decision. Checks run in order ethertype, protocol, TCP offset,
  // length; a field that never arrived makes the frame truncated at the
  // first check that needs it.
  function automatic locate_t judge_frame();
    locate_t r;
    int      caplen;
    int      hdrs;
    r      = '0;
    caplen = cnt_bytes;
    hdrs   = ETH_HDR_BYTES + ip_len_cap + tcp_len_cap;
    if (!seen_cap[SEEN_ETYPE]) begin
      r.verdict = VERDICT_TRUNCATED;
    end else if (etype_cap != ETYPE_IPV4) begin
      r.verdict = VERDICT_NOT_IPV4;
    end else if (!seen_cap[SEEN_PROTO]) begin
      r.verdict = VERDICT_TRUNCATED;
    end else if (proto_cap != PROTO_TCP) begin
      r.verdict = VERDICT_NOT_TCP;
    end else if (!seen_cap[SEEN_TCP]) begin
      r.verdict = VERDICT_TRUNCATED;
    end else if (caplen <= hdrs || caplen - hdrs > int'(cfg_max_len)) begin
      r.verdict = VERDICT_BAD_LEN;
    end else begin
      r.verdict = VERDICT_ACCEPT;
      r.offset  = 8'(hdrs);
      r.length  = 11'(caplen - hdrs);
    end
    clear_capture();
    return r;
  endfunction

  // Every accepted byte goes through here; bytes past the cap are dropped
  // but their end flag still closes the frame.
  function automatic void track_byte(logic [7:0] b, logic last);
    if (cnt_bytes < FRAME_CAP) begin
      capture_field(cnt_bytes, b);
      cnt_bytes++;
    end
    if (last) pending_verdicts.push_back(judge_frame());
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Queue one frame of len bytes with the given header fields dropped in at
  // their positions; everything else, the IP version nibble and the low
  // nibble of the TCP offset byte included, is random.
  function automatic void queue_frame(int len, logic [15:0] etype, logic [3:0] ihl,
                                      logic [7:0] proto, logic [3:0] doff);
    frame_item_t it;
    int          tcp_pos;
    tcp_pos = ETH_HDR_BYTES + 4 * ihl + TCP_OFFS_BYTE;
    for (int i = 0; i < len; i++) begin
      it.data = 8'($urandom);
      if (i == POS_ETYPE_HI) it.data = etype[15:8];
      else if (i == POS_ETYPE_LO) it.data = etype[7:0];
      else if (i == POS_IHL) it.data[3:0] = ihl;
      else if (i == POS_PROTO) it.data = proto;
      else if (i == tcp_pos) it.data[7:4] = doff;
      it.last = (i == len - 1);
      tx_bytes.push_back(it);
    end
  endfunction

  // Mostly well-formed TCP frames with payload lengths around the limits,
  // then near misses (wrong ethertype or protocol) and pure noise.
  function automatic int random_frame();
    int          r;
    int          len;
    int          pl;
    int          hdrs;
    int          tpos;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [15:0] et;
    logic [7:0]  pr;
    r    = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    hdrs = ETH_HDR_BYTES + 4 * ihl + 4 * doff;
    tpos = ETH_HDR_BYTES + 4 * ihl + TCP_OFFS_BYTE;
    if (r < 70) begin
      et = ETYPE_IPV4;
      pr = PROTO_TCP;
      case ($urandom_range(0, 7))
        0: pl = 0;
        1: pl = 1;
        2: pl = (cfg_max_len <= 64) ? int'(cfg_max_len) : int'($urandom_range(1, 30));
        3: pl = (cfg_max_len <= 64) ? int'(cfg_max_len) + 1 : int'($urandom_range(1, 30));
        default: pl = $urandom_range(1, 30);
      endcase
      len = hdrs + pl;
      // cut some off before the TCP offset byte
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, tpos);
      if (len < 1) len = 1;
    end else if (r < 85) begin
      et  = $urandom_range(0, 1) ? 16'($urandom) : ETYPE_IPV4;
      pr  = 8'($urandom);
      len = $urandom_range(14, 80);
    end else begin
      et  = 16'($urandom);
      pr  = 8'($urandom);
      len = $urandom_range(1, 40);
    end
    queue_frame(len, et, ihl, pr, doff);
    return len;
  endfunction

  // Idle lengths: mostly none or short, a few long; none at all while calm
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------------

  task automatic apb_cycle(bit wr, logic [10:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_PAYLOAD_ADDR;
    pwdata  <= {21'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      cfg_max_len = val;
    end else if (prdata[10:0] !== cfg_max_len) begin
      faults++;
      $error("max_payload_len readback: expected %0d, got %0d", cfg_max_len, prdata[10:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_max_payload(logic [10:0] val);
    apb_cycle(1'b1, val);
    apb_cycle(1'b0, val);
  endtask

  // Hold off until every queued byte is taken and every verdict is back,
  // then let the registered result settle.
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new byte at the falling edge once the last one was taken;
  // receiver stall bursts are picked here too.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    frame_item_t cur;
    int          n;
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          cur = tx_bytes.pop_front();
          frame_byte <= cur.data;
          frame_end  <= cur.last;
          in_valid   <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;

      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        n = pick_gap(rx_calm);
        if (n > 0) begin
          rx_hold = n - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted byte, then check any accepted result
  // against the oldest pending verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    locate_t want;
    if (!rst) begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) track_byte(frame_byte, frame_end);
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          faults++;
          $error("result with no frame closed: verdict %0d offset %0d length %0d",
                 verdict, payload_offset, payload_bytes);
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict !== want.verdict) begin
            faults++;
            $error("verdict: expected %0d, got %0d", want.verdict, verdict);
          end
          if (payload_offset !== want.offset) begin
            faults++;
            $error("payload_offset: expected %0d, got %0d", want.offset, payload_offset);
          end
          if (payload_bytes !== want.length) begin
            faults++;
            $error("payload_bytes: expected %0d, got %0d", want.length, payload_bytes);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int          rnd_bytes;
    int          rnd_frames;
    int          chunk;
    int          k;
    logic [10:0] lim;
    clear_capture();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at the reset limit of 260
    queue_frame(1, 16'hFFFF, 4'hF, 8'hFF, 4'hF);           // one byte, truncated
    queue_frame(13, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);    // ends on ethertype high byte
    queue_frame(14, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);    // ends before protocol
    queue_frame(60, 16'h86DD, 4'd5, PROTO_TCP, 4'd5);      // not IPv4
    queue_frame(14, 16'h0000, 4'd5, PROTO_TCP, 4'd5);      // not IPv4, ethertype zero
    queue_frame(60, ETYPE_IPV4, 4'd5, 8'd17, 4'd5);        // not TCP
    queue_frame(60, ETYPE_IPV4, 4'd5, 8'hFF, 4'd5);        // not TCP, protocol all ones
    queue_frame(40, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);    // ends before TCP offset byte
    queue_frame(54, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);    // zero payload
    queue_frame(55, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);    // one payload byte
    queue_frame(314, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);   // payload right at 260
    queue_frame(315, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);   // payload one over
    queue_frame(27, ETYPE_IPV4, 4'd0, PROTO_TCP, 4'd0);    // IHL 0, offset byte at 26
    queue_frame(40, ETYPE_IPV4, 4'd2, PROTO_TCP, 4'd5);    // short IHL with real TCP offset
    queue_frame(140, ETYPE_IPV4, 4'hF, PROTO_TCP, 4'hF);   // largest headers, offset 134
    queue_frame(134, ETYPE_IPV4, 4'hF, PROTO_TCP, 4'hF);   // largest headers, no payload
    wait_idle();

    // Long frame past the byte counter saturation point
    set_max_payload(11'd2047);
    queue_frame(FRAME_CAP + 2, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);
    wait_idle();

    // Smallest limit: one payload byte passes, two do not
    set_max_payload(11'd1);
    queue_frame(55, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);
    queue_frame(56, ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5);
    wait_idle();

    // Random frames in phases, limit rewritten between phases with the
    // block drained each time
    rnd_bytes  = 0;
    rnd_frames = 0;
    k = 0;
    while (rnd_bytes < 840 || rnd_frames < 24) begin
      case (k % 6)
        0: lim = 11'd2047;
        1: lim = 11'($urandom_range(1, 60));
        2: lim = 11'd1;
        3: lim = 11'($urandom_range(1, 2047));
        4: lim = 11'd260;
        default: lim = 11'($urandom_range(20, 40));
      endcase
      set_max_payload(lim);
      chunk = 0;
      while (chunk < 140) begin
        chunk += random_frame();
        rnd_frames++;
      end
      rnd_bytes += chunk;
      wait_idle();
      k++;
    end

    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
